// ----- rtl/tbgc_pkg.sv -----
// Package: shared types, constants and helpers for the three-button gesture classifier.
package tbgc_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_BITS  = 16;
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	typedef logic [TIME_BITS-1:0] tstamp_t;
	typedef logic [CFG_BITS-1:0]  cfg_val_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_FACTORY     = 3'd1,
		EV_RECONFIG    = 3'd2,
		EV_MODE_DOUBLE = 3'd3,
		EV_CANCEL      = 3'd4,
		EV_LONG        = 3'd5,
		EV_ACT_DOUBLE  = 3'd6,
		EV_ACT_SHORT   = 3'd7
	} event_t;

	typedef enum logic [2:0] {
		REG_DEBOUNCE = 3'd0,
		REG_SHORT    = 3'd1,
		REG_LONG     = 3'd2,
		REG_DOUBLE   = 3'd3,
		REG_RECONFIG = 3'd4,
		REG_FACTORY  = 3'd5
	} reg_idx_t;

	localparam cfg_val_t DEBOUNCE_RST = 16'd50;
	localparam cfg_val_t SHORT_RST    = 16'd800;
	localparam cfg_val_t LONG_RST     = 16'd2000;
	localparam cfg_val_t DOUBLE_RST   = 16'd400;
	localparam cfg_val_t RECONFIG_RST = 16'd3000;
	localparam cfg_val_t FACTORY_RST  = 16'd8000;

	typedef struct packed {
		cfg_val_t debounce_ms;
		cfg_val_t short_max_ms;
		cfg_val_t action_long_ms;
		cfg_val_t double_click_ms;
		cfg_val_t reconfig_ms;
		cfg_val_t factory_ms;
	} cfg_t;

	typedef struct packed {
		logic    lvl;
		tstamp_t chg_time;
		tstamp_t begin_time;
		logic    held;
	} btn_t;

	function automatic tstamp_t ext(input cfg_val_t v);
		return tstamp_t'(v);
	endfunction

endpackage

// ----- rtl/tbgc_regs.sv -----
// Configuration register file behind the APB-style port.
module tbgc_regs
	import tbgc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;
	cfg_val_t wval;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wval   = pwdata[CFG_BITS-1:0];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= DEBOUNCE_RST;
			cfg_q.short_max_ms    <= SHORT_RST;
			cfg_q.action_long_ms  <= LONG_RST;
			cfg_q.double_click_ms <= DOUBLE_RST;
			cfg_q.reconfig_ms     <= RECONFIG_RST;
			cfg_q.factory_ms      <= FACTORY_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE: cfg_q.debounce_ms     <= wval;
				REG_SHORT:    cfg_q.short_max_ms    <= wval;
				REG_LONG:     cfg_q.action_long_ms  <= wval;
				REG_DOUBLE:   cfg_q.double_click_ms <= wval;
				REG_RECONFIG: cfg_q.reconfig_ms     <= wval;
				REG_FACTORY:  cfg_q.factory_ms      <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DEBOUNCE: prdata = DATA_BITS'(cfg_q.debounce_ms);
			REG_SHORT:    prdata = DATA_BITS'(cfg_q.short_max_ms);
			REG_LONG:     prdata = DATA_BITS'(cfg_q.action_long_ms);
			REG_DOUBLE:   prdata = DATA_BITS'(cfg_q.double_click_ms);
			REG_RECONFIG: prdata = DATA_BITS'(cfg_q.reconfig_ms);
			REG_FACTORY:  prdata = DATA_BITS'(cfg_q.factory_ms);
			default:      prdata = '0;
		endcase
	end

endmodule

// ----- rtl/tbgc_classify.sv -----
// Button tracking state and per-poll gesture classification.
module tbgc_classify
	import tbgc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    mode_lvl,
	input  logic    act_lvl,
	input  logic    sys_lvl,
	input  logic    busy,
	input  tstamp_t now,
	input  cfg_t    cfg,
	output event_t  ev
);

	btn_t    mode_q, act_q, sys_q;
	logic    long_fired_q, mwait_q, await_q;
	tstamp_t mtime_q, atime_q;

	btn_t    mode_d, act_d, sys_d;
	logic    long_fired_d, mwait_d, await_d;
	tstamp_t mtime_d, atime_d;

	always_comb begin
		logic    done;
		logic    stable;
		tstamp_t hold;
		tstamp_t deb, dbl;

		mode_d       = mode_q;
		act_d        = act_q;
		sys_d        = sys_q;
		long_fired_d = long_fired_q;
		mwait_d      = mwait_q;
		mtime_d      = mtime_q;
		await_d      = await_q;
		atime_d      = atime_q;
		ev           = EV_NONE;
		done         = 1'b0;
		hold         = '0;
		deb          = ext(cfg.debounce_ms);
		dbl          = ext(cfg.double_click_ms);

		// system button
		if (sys_lvl != sys_q.lvl) begin
			sys_d.lvl      = sys_lvl;
			sys_d.chg_time = now;
		end
		stable = (now - sys_d.chg_time) >= deb;
		if (stable) begin
			if (sys_lvl && !sys_q.held) begin
				sys_d.held       = 1'b1;
				sys_d.begin_time = now;
			end else if (!sys_lvl && sys_q.held) begin
				sys_d.held = 1'b0;
				hold       = now - sys_q.begin_time;
				if (hold >= ext(cfg.factory_ms)) begin
					ev   = EV_FACTORY;
					done = 1'b1;
				end else if (hold >= ext(cfg.reconfig_ms)) begin
					ev   = EV_RECONFIG;
					done = 1'b1;
				end
			end
		end

		// mode button
		if (!done) begin
			hold = '0;
			if (mode_lvl != mode_q.lvl) begin
				mode_d.lvl      = mode_lvl;
				mode_d.chg_time = now;
			end
			stable = (now - mode_d.chg_time) >= deb;
			if (stable) begin
				if (mode_lvl && !mode_q.held) begin
					mode_d.held       = 1'b1;
					mode_d.begin_time = now;
				end else if (!mode_lvl && mode_q.held) begin
					mode_d.held = 1'b0;
					hold        = now - mode_q.begin_time;
				end
			end
			if (hold != '0 && hold < ext(cfg.short_max_ms)) begin
				if (mwait_q && (now - mtime_q) <= dbl) begin
					mwait_d = 1'b0;
					ev      = EV_MODE_DOUBLE;
					done    = 1'b1;
				end else begin
					mwait_d = 1'b1;
					mtime_d = now;
				end
			end
		end

		if (!done && mwait_d && (now - mtime_d) > dbl)
			mwait_d = 1'b0;

		// action button
		if (!done) begin
			if (act_lvl != act_q.lvl) begin
				act_d.lvl      = act_lvl;
				act_d.chg_time = now;
			end
			stable = (now - act_d.chg_time) >= deb;
			if (busy) begin
				await_d = 1'b0;
				if (stable) begin
					if (act_lvl && !act_q.held) begin
						act_d.held = 1'b1;
						ev         = EV_CANCEL;
					end else if (!act_lvl) begin
						act_d.held = 1'b0;
					end
				end
				done = 1'b1;
			end else if (stable) begin
				if (act_lvl && !act_q.held) begin
					act_d.held       = 1'b1;
					act_d.begin_time = now;
					long_fired_d     = 1'b0;
				end else if (act_lvl) begin
					if (!long_fired_q &&
					    (now - act_q.begin_time) >= ext(cfg.action_long_ms)) begin
						long_fired_d = 1'b1;
						await_d      = 1'b0;
						ev           = EV_LONG;
						done         = 1'b1;
					end
				end else if (act_q.held) begin
					act_d.held   = 1'b0;
					long_fired_d = 1'b0;
					if (!long_fired_q) begin
						if (await_q && (now - atime_q) <= dbl) begin
							await_d = 1'b0;
							ev      = EV_ACT_DOUBLE;
							done    = 1'b1;
						end else begin
							await_d = 1'b1;
							atime_d = now;
						end
					end
				end
			end
		end

		if (!done && await_d && (now - atime_d) > dbl) begin
			await_d = 1'b0;
			ev      = EV_ACT_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= '0;
			act_q        <= '0;
			sys_q        <= '0;
			long_fired_q <= 1'b0;
			mwait_q      <= 1'b0;
			mtime_q      <= '0;
			await_q      <= 1'b0;
			atime_q      <= '0;
		end else if (step) begin
			mode_q       <= mode_d;
			act_q        <= act_d;
			sys_q        <= sys_d;
			long_fired_q <= long_fired_d;
			mwait_q      <= mwait_d;
			mtime_q      <= mtime_d;
			await_q      <= await_d;
			atime_q      <= atime_d;
		end
	end

endmodule

// ----- rtl/three_button_gesture_classifier_unit.sv -----
// Top level: input register, classifier, result register and config port.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one poll per transfer: three raw
//   button levels, busy_req and the now_ms timestamp. Output channel
//   (out_valid/out_stall) returns exactly one event_code per poll, in order;
//   event_code 0 means no event.
//   A poll goes through the input register, then is classified into the
//   result register. Throughput: one poll per cycle unless out_stall holds a
//   waiting result; the classifier state updates in the same cycle the poll
//   leaves the input register, so back-to-back polls chain. When out_stall is
//   high with a result waiting, the input register holds and in_stall rises;
//   with an empty result register no stall is seen. Reset (arst_n low) clears
//   all button tracking state, pending clicks and both valid flags, and loads
//   the register defaults. The user must write registers through the APB-style
//   port only while no poll is in flight; the block does not enforce this.
module three_button_gesture_classifier_unit
	import tbgc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode_down,
	input  logic                 action_down,
	input  logic                 system_down,
	input  logic                 busy_req,
	input  logic [31:0]          now_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           event_code,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	cfg_t    cfg;
	logic    valid_s1;
	logic    mode_s1, act_s1, sys_s1, busy_s1;
	tstamp_t now_s1;
	logic    out_valid_q;
	event_t  event_q;
	event_t  ev;
	logic    advance;
	logic    take;

	assign advance    = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall   = valid_s1 & ~advance;
	assign take       = in_valid & ~in_stall;
	assign out_valid  = out_valid_q;
	assign event_code = event_q;

	tbgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tbgc_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.mode_lvl (mode_s1),
		.act_lvl  (act_s1),
		.sys_lvl  (sys_s1),
		.busy     (busy_s1),
		.now      (now_s1),
		.cfg      (cfg),
		.ev       (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode_down;
			act_s1  <= action_down;
			sys_s1  <= system_down;
			busy_s1 <= busy_req;
			now_s1  <= now_ms[TIME_BITS-1:0];
		end
		if (advance)
			event_q <= ev;
	end

endmodule
